// ----- src/ascale_pkg.sv -----
`default_nettype none
package ascale_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int IN_SAMPLE_BITS  = 10;
    localparam int CFG_BITS        = 8;
    localparam int CHAN_BITS       = 5;
    localparam int VALUE_BITS      = 15;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 8'd255;

    localparam logic OP_WAKE = 1'b0;
    localparam logic OP_DONE = 1'b1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_READING = 1'b1;

    localparam logic PH_SLEEP   = 1'b0;
    localparam logic PH_CONVERT = 1'b1;

    localparam logic [1:0] IDX_CH3  = 2'd0;
    localparam logic [1:0] IDX_CH7  = 2'd1;
    localparam logic [1:0] IDX_CH29 = 2'd2;
    localparam logic [1:0] IDX_CH31 = 2'd3;

    localparam logic [CHAN_BITS-1:0] SCAN_CHANNELS [4] = '{5'd3, 5'd7, 5'd29, 5'd31};

    localparam int NUM_CH3  = 100;
    localparam int DEN_CH3  = 2505;
    localparam int NUM_CH7  = 1;
    localparam int DEN_CH7  = 25;
    localparam int NUM_CH29 = 1;
    localparam int DEN_CH29 = 2089;
    localparam int NUM_CH31 = 10;
    localparam int DEN_CH31 = 248;
    localparam int OFFSET_CH29 = 40;

    // The largest divisor sets the guard bits of the reciprocal.
    localparam int GUARD_BITS = $clog2(DEN_CH3);

    localparam int VALUE_MAX = 16383;
    localparam int VALUE_MIN = -16384;

    typedef struct packed {
        logic       has_read;
        logic       has_req;
        logic [1:0] read_idx;
        logic [1:0] req_idx;
    } t_job_ctl;

endpackage
`default_nettype wire

// ----- src/ascale_in_if.sv -----
`default_nettype none
interface ascale_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic [ascale_pkg::IN_SAMPLE_BITS-1:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);
endinterface
`default_nettype wire

// ----- src/ascale_out_if.sv -----
`default_nettype none
interface ascale_out_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     kind;
    logic [ascale_pkg::CHAN_BITS-1:0]         channel;
    logic signed [ascale_pkg::VALUE_BITS-1:0] value;
    logic                                     last;

    modport source (output valid, output kind, output channel, output value, output last,
                    input ready);
    modport sink   (input valid, input kind, input channel, input value, input last,
                    output ready);
endinterface
`default_nettype wire

// ----- src/ascale_front.sv -----
`default_nettype none
module ascale_front #(
    parameter int SAMPLE_BITS = ascale_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    ascale_in_if.sink                              i_in,
    input  logic                                   i_cfg_we,
    input  logic [ascale_pkg::CFG_BITS-1:0]        i_cfg_wdata,
    input  logic                                   i_full,
    output logic                                   o_push,
    output ascale_pkg::t_job_ctl                   o_job,
    output logic [SAMPLE_BITS+ascale_pkg::CFG_BITS-1:0] o_sum
);

    localparam int SUM_BITS = SAMPLE_BITS + ascale_pkg::CFG_BITS;

    logic [ascale_pkg::CFG_BITS-1:0] r_cfg;
    logic                            r_phase, n_phase;
    logic [1:0]                      r_scan, n_scan;
    logic [SUM_BITS-1:0]             r_sum, n_sum;
    logic [ascale_pkg::CFG_BITS-1:0] r_left, n_left;

    logic                   w_acc;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [SUM_BITS-1:0]    w_add;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_sample   = SAMPLE_BITS'(i_in.sample);
    assign w_add      = r_sum + SUM_BITS'(w_sample);

    always_comb begin
        n_phase = r_phase;
        n_scan  = r_scan;
        n_sum   = r_sum;
        n_left  = r_left;
        o_push  = 1'b0;
        o_job   = '0;
        o_sum   = w_add;
        if (w_acc) begin
            if (i_in.opcode == ascale_pkg::OP_WAKE) begin
                if (r_phase == ascale_pkg::PH_SLEEP) begin
                    o_push        = 1'b1;
                    o_job.has_req = 1'b1;
                    o_job.req_idx = r_scan;
                    n_sum         = '0;
                    n_left        = r_cfg;
                    n_phase       = ascale_pkg::PH_CONVERT;
                end
            end else if (r_phase == ascale_pkg::PH_CONVERT) begin
                o_push = 1'b1;
                if (r_left != '0) begin
                    n_left        = r_left - 1'b1;
                    n_sum         = w_add;
                    o_job.has_req = 1'b1;
                    o_job.req_idx = r_scan;
                end else if (r_scan == ascale_pkg::IDX_CH31) begin
                    o_job.has_read = 1'b1;
                    o_job.read_idx = r_scan;
                    n_scan         = ascale_pkg::IDX_CH3;
                    n_phase        = ascale_pkg::PH_SLEEP;
                    n_sum          = '0;
                end else begin
                    o_job.has_read = 1'b1;
                    o_job.read_idx = r_scan;
                    o_job.has_req  = 1'b1;
                    o_job.req_idx  = r_scan + 2'd1;
                    n_scan         = r_scan + 2'd1;
                    n_sum          = '0;
                    n_left         = r_cfg;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= ascale_pkg::CFG_RESET;
            r_phase <= ascale_pkg::PH_SLEEP;
            r_scan  <= ascale_pkg::IDX_CH3;
            r_sum   <= '0;
            r_left  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_phase <= n_phase;
            r_scan  <= n_scan;
            r_sum   <= n_sum;
            r_left  <= n_left;
        end
    end

    // While sleeping the running sum is always clear.
    a_sleep_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ascale_pkg::PH_SLEEP) |-> (r_sum == '0))
        else $error("sum not clear while sleeping");

endmodule
`default_nettype wire

// ----- src/ascale_queue.sv -----
`default_nettype none
module ascale_queue #(
    parameter int SAMPLE_BITS = ascale_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_push,
    input  ascale_pkg::t_job_ctl                        i_job,
    input  logic [SAMPLE_BITS+ascale_pkg::CFG_BITS-1:0] i_sum,
    input  logic                                        i_pop,
    output logic                                        o_full,
    output logic                                        o_valid,
    output ascale_pkg::t_job_ctl                        o_job,
    output logic [SAMPLE_BITS+ascale_pkg::CFG_BITS-1:0] o_sum
);

    localparam int SUM_BITS = SAMPLE_BITS + ascale_pkg::CFG_BITS;
    localparam int DEPTH    = ascale_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    ascale_pkg::t_job_ctl r_ctl [DEPTH];
    logic [SUM_BITS-1:0]  r_data [DEPTH];
    logic [PTR_BITS-1:0]  r_wptr, r_rptr;
    logic [CNT_BITS-1:0]  r_count;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_ctl[r_rptr];
    assign o_sum   = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wptr]  <= i_job;
            r_data[r_wptr] <= i_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- src/ascale_back.sv -----
`default_nettype none
module ascale_back #(
    parameter int SAMPLE_BITS = ascale_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  ascale_pkg::t_job_ctl                        i_job,
    input  logic [SAMPLE_BITS+ascale_pkg::CFG_BITS-1:0] i_sum,
    output logic                                        o_pop,
    ascale_out_if.source                                o_out
);

    localparam int SUM_BITS  = SAMPLE_BITS + ascale_pkg::CFG_BITS;
    localparam int SHIFT     = SUM_BITS + ascale_pkg::GUARD_BITS;
    localparam int PROD_BITS = SUM_BITS + SHIFT;
    localparam int DIFF_BITS = SUM_BITS + 2;

    // Rounded-up reciprocals, exact for every sum below two to the SUM_BITS.
    localparam logic [63:0] M_CH3  = ((64'd1 << SHIFT) * 64'(ascale_pkg::NUM_CH3)
                                      + 64'(ascale_pkg::DEN_CH3) - 64'd1)
                                     / 64'(ascale_pkg::DEN_CH3);
    localparam logic [63:0] M_CH7  = ((64'd1 << SHIFT) * 64'(ascale_pkg::NUM_CH7)
                                      + 64'(ascale_pkg::DEN_CH7) - 64'd1)
                                     / 64'(ascale_pkg::DEN_CH7);
    localparam logic [63:0] M_CH29 = ((64'd1 << SHIFT) * 64'(ascale_pkg::NUM_CH29)
                                      + 64'(ascale_pkg::DEN_CH29) - 64'd1)
                                     / 64'(ascale_pkg::DEN_CH29);
    localparam logic [63:0] M_CH31 = ((64'd1 << SHIFT) * 64'(ascale_pkg::NUM_CH31)
                                      + 64'(ascale_pkg::DEN_CH31) - 64'd1)
                                     / 64'(ascale_pkg::DEN_CH31);

    localparam logic signed [DIFF_BITS-1:0] SAT_HI = DIFF_BITS'(ascale_pkg::VALUE_MAX);
    localparam logic signed [DIFF_BITS-1:0] SAT_LO = DIFF_BITS'(ascale_pkg::VALUE_MIN);
    localparam logic signed [DIFF_BITS-1:0] OFFSET = DIFF_BITS'(ascale_pkg::OFFSET_CH29);

    logic                                     r_valid;
    logic                                     r_kind;
    logic [ascale_pkg::CHAN_BITS-1:0]         r_chan;
    logic signed [ascale_pkg::VALUE_BITS-1:0] r_value;
    logic                                     r_last;
    logic                                     r_half, n_half;

    logic                                     w_load, w_take, w_both, w_emit_read;
    logic [SHIFT-1:0]                         w_mult;
    logic [PROD_BITS-1:0]                     w_prod;
    logic [SUM_BITS-1:0]                      w_quot;
    logic signed [DIFF_BITS-1:0]              w_diff;
    logic signed [ascale_pkg::VALUE_BITS-1:0] w_scaled;

    assign w_load      = !r_valid || o_out.ready;
    assign w_take      = w_load && i_valid;
    assign w_both      = i_job.has_read && i_job.has_req;
    assign w_emit_read = i_job.has_read && !r_half;
    assign o_pop       = w_take && (!w_both || r_half);
    assign n_half      = w_take ? (w_both && !r_half) : r_half;

    always_comb begin
        unique case (i_job.read_idx)
            ascale_pkg::IDX_CH3:  w_mult = M_CH3[SHIFT-1:0];
            ascale_pkg::IDX_CH7:  w_mult = M_CH7[SHIFT-1:0];
            ascale_pkg::IDX_CH29: w_mult = M_CH29[SHIFT-1:0];
            default:              w_mult = M_CH31[SHIFT-1:0];
        endcase
    end

    assign w_prod = PROD_BITS'(i_sum) * PROD_BITS'(w_mult);
    assign w_quot = w_prod[PROD_BITS-1:SHIFT];

    always_comb begin
        w_diff = $signed({2'b00, w_quot});
        if (i_job.read_idx == ascale_pkg::IDX_CH29) begin
            w_diff = $signed({2'b00, w_quot}) - OFFSET;
        end
        if (w_diff > SAT_HI) begin
            w_scaled = ascale_pkg::VALUE_BITS'(ascale_pkg::VALUE_MAX);
        end else if (w_diff < SAT_LO) begin
            w_scaled = ascale_pkg::VALUE_BITS'(ascale_pkg::VALUE_MIN);
        end else begin
            w_scaled = w_diff[ascale_pkg::VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (w_emit_read) begin
                r_kind  <= ascale_pkg::KIND_READING;
                r_chan  <= ascale_pkg::SCAN_CHANNELS[i_job.read_idx];
                r_value <= w_scaled;
                r_last  <= !i_job.has_req;
            end else begin
                r_kind  <= ascale_pkg::KIND_REQUEST;
                r_chan  <= ascale_pkg::SCAN_CHANNELS[i_job.req_idx];
                r_value <= '0;
                r_last  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= i_valid;
            end
            r_half <= n_half;
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.kind    = r_kind;
    assign o_out.channel = r_chan;
    assign o_out.value   = r_value;
    assign o_out.last    = r_last;

    // The second word of a paired job is pending only while that job heads the queue.
    a_half_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (i_valid && i_job.has_read && i_job.has_req))
        else $error("pending request without a paired job");

    a_half_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_half && w_load) |=> !r_half)
        else $error("paired job not retired");

endmodule
`default_nettype wire

// ----- src/adc_scan_oversample_scaler.sv -----
// Channel   Direction  Handshake     Words
// i_in      in         valid/ready   opcode, sample
// o_out     out        valid/ready   kind, channel, value, last
// i_cfg     in         write enable  samples_minus_one
//
// One input word is taken per cycle while the four-entry job queue has room.
// A result word passes through the job queue and then the output register before it leaves.
// A job holding a reading followed by a request leaves the output register as two words in turn.
// Reset is synchronous and active low; no memory needs clearing.
// Either side may stall; the job queue absorbs the difference.
`default_nettype none
module adc_scan_oversample_scaler #(
    parameter int SAMPLE_BITS = ascale_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ascale_in_if.sink                       i_in,
    ascale_out_if.source                    o_out,
    input  logic                            i_cfg_we,
    input  logic [ascale_pkg::CFG_BITS-1:0] i_cfg_wdata
);

    localparam int SUM_BITS = SAMPLE_BITS + ascale_pkg::CFG_BITS;

    logic                 w_push, w_pop, w_full, w_valid;
    ascale_pkg::t_job_ctl w_job_in, w_job_out;
    logic [SUM_BITS-1:0]  w_sum_in, w_sum_out;

    ascale_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_job_in),
        .o_sum       (w_sum_in)
    );

    ascale_queue #(.SAMPLE_BITS(SAMPLE_BITS)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_sum   (w_sum_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_job   (w_job_out),
        .o_sum   (w_sum_out)
    );

    ascale_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_job   (w_job_out),
        .i_sum   (w_sum_out),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// ----- verif/tb_adc_scan_oversample_scaler.sv -----
`timescale 1ns / 100ps
module tb_adc_scan_oversample_scaler;

    localparam int ITEM_TARGET    = 1850;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_ROWS       = 10;
    localparam int SUM_BITS       = ascale_pkg::SAMPLE_BITS_DEF + ascale_pkg::CFG_BITS;

    localparam logic [ascale_pkg::IN_SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    typedef struct packed {
        logic                                     kind;
        logic [ascale_pkg::CHAN_BITS-1:0]         channel;
        logic signed [ascale_pkg::VALUE_BITS-1:0] value;
        logic                                     last;
    } t_exp_word;

    typedef struct packed {
        logic                                  op;
        logic [ascale_pkg::IN_SAMPLE_BITS-1:0] smp;
        logic                                  gives_word;
        t_exp_word                             word;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [ascale_pkg::CFG_BITS-1:0] cfg_wdata;

    ascale_in_if  in_ch ();
    ascale_out_if out_ch ();

    adc_scan_oversample_scaler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    logic                            scan_phase;
    logic [1:0]                      scan_idx;
    logic [SUM_BITS-1:0]             acc_sum;
    logic [ascale_pkg::CFG_BITS-1:0] left_cnt;
    logic [ascale_pkg::CFG_BITS-1:0] count_cfg;

    t_exp_word step_out [2];
    t_exp_word pending_words [$];
    t_dir_row  dir_rows [DIR_ROWS];

    int mismatches = 0;
    int words_out  = 0;
    int burst_left = 0;

    function automatic t_exp_word word_of(logic k, logic [ascale_pkg::CHAN_BITS-1:0] ch,
                                          logic signed [ascale_pkg::VALUE_BITS-1:0] v,
                                          logic lst);
        t_exp_word w;
        w.kind    = k;
        w.channel = ch;
        w.value   = v;
        w.last    = lst;
        return w;
    endfunction

    function automatic logic signed [ascale_pkg::VALUE_BITS-1:0] scaled_reading(
            logic [1:0] idx, logic [SUM_BITS-1:0] sum);
        longint v;
        case (idx)
            ascale_pkg::IDX_CH3:
                v = longint'(sum) * ascale_pkg::NUM_CH3 / ascale_pkg::DEN_CH3;
            ascale_pkg::IDX_CH7:
                v = longint'(sum) / ascale_pkg::DEN_CH7;
            ascale_pkg::IDX_CH29:
                v = longint'(sum) / ascale_pkg::DEN_CH29 - ascale_pkg::OFFSET_CH29;
            default:
                v = longint'(sum) * ascale_pkg::NUM_CH31 / ascale_pkg::DEN_CH31;
        endcase
        if (v > ascale_pkg::VALUE_MAX) v = ascale_pkg::VALUE_MAX;
        if (v < ascale_pkg::VALUE_MIN) v = ascale_pkg::VALUE_MIN;
        return v[ascale_pkg::VALUE_BITS-1:0];
    endfunction

    function automatic void open_channel();
        acc_sum    = '0;
        left_cnt   = count_cfg;
        scan_phase = ascale_pkg::PH_CONVERT;
    endfunction

    // Advances the scan state by one accepted word and leaves the words it causes in step_out.
    function automatic int scan_step(logic op, logic [ascale_pkg::IN_SAMPLE_BITS-1:0] smp);
        logic [ascale_pkg::CHAN_BITS-1:0] chan;
        chan = ascale_pkg::SCAN_CHANNELS[scan_idx];
        if (op == ascale_pkg::OP_WAKE) begin
            if (scan_phase == ascale_pkg::PH_CONVERT) return 0;
            open_channel();
            step_out[0] = word_of(ascale_pkg::KIND_REQUEST, chan, '0, 1'b1);
            return 1;
        end
        if (scan_phase == ascale_pkg::PH_SLEEP) return 0;
        acc_sum = acc_sum + SUM_BITS'(smp);
        if (left_cnt != 0) begin
            left_cnt = left_cnt - 1'b1;
            step_out[0] = word_of(ascale_pkg::KIND_REQUEST, chan, '0, 1'b1);
            return 1;
        end
        step_out[0] = word_of(ascale_pkg::KIND_READING, chan,
                              scaled_reading(scan_idx, acc_sum),
                              scan_idx == ascale_pkg::IDX_CH31);
        if (scan_idx == ascale_pkg::IDX_CH31) begin
            scan_idx   = ascale_pkg::IDX_CH3;
            scan_phase = ascale_pkg::PH_SLEEP;
            acc_sum    = '0;
            return 1;
        end
        scan_idx = scan_idx + 2'd1;
        open_channel();
        step_out[1] = word_of(ascale_pkg::KIND_REQUEST, ascale_pkg::SCAN_CHANNELS[scan_idx],
                              '0, 1'b1);
        return 2;
    endfunction

    task automatic offer_word(logic op, logic [ascale_pkg::IN_SAMPLE_BITS-1:0] smp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.sample <= smp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic load_count(logic [ascale_pkg::CFG_BITS-1:0] val);
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        count_cfg  = val;
        burst_left = 0;
    endtask

    initial begin
        int                                    counted;
        int                                    span;
        int                                    k;
        int                                    n;
        int                                    sel;
        bit                                    first;
        bit                                    big_done;
        bit                                    hot;
        logic                                  op;
        logic [ascale_pkg::IN_SAMPLE_BITS-1:0] smp;
        logic [ascale_pkg::CFG_BITS-1:0]       cfg_val;
        logic [1:0]                            nxt;

        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.opcode <= ascale_pkg::OP_WAKE;
        in_ch.sample <= '0;
        scan_phase = ascale_pkg::PH_SLEEP;
        scan_idx   = ascale_pkg::IDX_CH3;
        acc_sum    = '0;
        left_cnt   = '0;
        count_cfg  = ascale_pkg::CFG_RESET;

        // The directed words run at the reset sample count, so channel 3 opens with it.
        dir_rows[0] = '{ascale_pkg::OP_DONE, SAMPLE_MAX, 1'b0, '0};
        dir_rows[1] = '{ascale_pkg::OP_DONE, '0, 1'b0, '0};
        dir_rows[2] = '{ascale_pkg::OP_WAKE, '0, 1'b1,
                        word_of(ascale_pkg::KIND_REQUEST, 5'd3, '0, 1'b1)};
        dir_rows[3] = '{ascale_pkg::OP_WAKE, SAMPLE_MAX, 1'b0, '0};
        dir_rows[4] = '{ascale_pkg::OP_DONE, SAMPLE_MAX, 1'b1,
                        word_of(ascale_pkg::KIND_REQUEST, 5'd3, '0, 1'b1)};
        dir_rows[5] = '{ascale_pkg::OP_DONE, '0, 1'b1,
                        word_of(ascale_pkg::KIND_REQUEST, 5'd3, '0, 1'b1)};
        dir_rows[6] = '{ascale_pkg::OP_WAKE, '0, 1'b0, '0};
        dir_rows[7] = '{ascale_pkg::OP_DONE, 10'd512, 1'b1,
                        word_of(ascale_pkg::KIND_REQUEST, 5'd3, '0, 1'b1)};
        dir_rows[8] = '{ascale_pkg::OP_DONE, 10'h155, 1'b1,
                        word_of(ascale_pkg::KIND_REQUEST, 5'd3, '0, 1'b1)};
        dir_rows[9] = '{ascale_pkg::OP_DONE, 10'h2AA, 1'b1,
                        word_of(ascale_pkg::KIND_REQUEST, 5'd3, '0, 1'b1)};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            offer_word(dir_rows[r].op, dir_rows[r].smp);
            void'(scan_step(dir_rows[r].op, dir_rows[r].smp));
            if (dir_rows[r].gives_word) pending_words.push_back(dir_rows[r].word);
        end

        counted  = 0;
        first    = 1'b1;
        big_done = 1'b0;
        while (counted < ITEM_TARGET) begin
            nxt = (scan_phase == ascale_pkg::PH_CONVERT) ? scan_idx + 2'd1 : scan_idx;
            hot = 1'b0;
            if (first) begin
                cfg_val = '0;
                span    = 300;
            end else if (!big_done && nxt == ascale_pkg::IDX_CH31) begin
                cfg_val  = '1;
                span     = 360;
                hot      = 1'b1;
                big_done = 1'b1;
            end else begin
                sel = $urandom_range(0, 9);
                if (sel < 6) cfg_val = ascale_pkg::CFG_BITS'($urandom_range(0, 3));
                else if (sel < 9) cfg_val = ascale_pkg::CFG_BITS'($urandom_range(4, 31));
                else cfg_val = ascale_pkg::CFG_BITS'($urandom_range(32, 80));
                span = $urandom_range(20, 80);
            end
            first = 1'b0;
            load_count(cfg_val);

            k = 0;
            while (k < span) begin
                if ($urandom_range(0, 99) < 8) op = 1'($urandom_range(0, 1));
                else op = (scan_phase == ascale_pkg::PH_CONVERT) ? ascale_pkg::OP_DONE
                                                                 : ascale_pkg::OP_WAKE;
                sel = $urandom_range(0, 7);
                if (hot || sel == 1) smp = SAMPLE_MAX;
                else if (sel == 0) smp = '0;
                else smp = ascale_pkg::IN_SAMPLE_BITS'($urandom_range(0, 1023));
                offer_word(op, smp);
                n = scan_step(op, smp);
                for (int j = 0; j < n; j++) pending_words.push_back(step_out[j]);
                if (n != 0) begin
                    k++;
                    counted++;
                end
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        int  mode;
        int  span;
        bit  held;
        mode = 0;
        span = 0;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held && words_out >= HOLD_AFTER) begin
                // A long hold-off lets the job queue fill so that the input stalls.
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 64);
                end
                span--;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (span % 3 != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_exp_word want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            words_out++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected word: kind %0d channel %0d value %0d last %0d",
                             out_ch.kind, out_ch.channel, out_ch.value, out_ch.last);
            end else begin
                want = pending_words.pop_front();
                if (out_ch.kind !== want.kind || out_ch.channel !== want.channel ||
                    out_ch.value !== want.value || out_ch.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"Word %0d: expected kind %0d channel %0d value %0d last %0d,",
                                  " got kind %0d channel %0d value %0d last %0d"},
                                 words_out, want.kind, want.channel, want.value, want.last,
                                 out_ch.kind, out_ch.channel, out_ch.value, out_ch.last);
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end
endmodule
